// ===== rtl/htach_pkg.sv =====
// Shared types and constants for the hall tachometer with idle timeout.
// No dependencies; imported by every module of the block.
package htach_pkg;

    localparam int ACTION_W     = 2;
    localparam int CAPTURE_W    = 16;
    localparam int PERIOD_W     = 16;
    localparam int TIME_W       = 13;
    localparam int DELAY_W      = 11;
    localparam int SPEED_W      = 16;
    localparam int TOTAL_W      = 32;
    localparam int TIMEOUT_W    = 20;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 2;

    localparam logic [ACTION_W-1:0] ACT_HALL   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUTTON = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

    localparam logic [APB_ADDR_W-1:0] ADDR_IDLE_TIMEOUT = 2'd0;

    localparam logic [TIMEOUT_W-1:0] IDLE_RESET_LENGTH = 20'd50000;

    // Divider: numerator of the speed figure, quotient width and step count
    localparam int DIV_Q_W    = 20;
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_Q_W-1:0]   SPEED_NUMERATOR = 20'd600000;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS       = 5'd20;
    localparam logic [SPEED_W-1:0]   SPEED_MAX       = 16'hFFFF;

    // ticks / 12 = ((ticks >> 2) * THIRD_RECIP) >> 16, exact for the 14-bit range
    localparam int QUARTER_W = 14;
    localparam int RECIP_W   = 15;
    localparam int PROD_W    = QUARTER_W + RECIP_W;
    localparam int RECIP_SH  = 16;
    localparam logic [RECIP_W-1:0] THIRD_RECIP = 15'd21846;

    typedef struct packed {
        logic reload;
        logic tick;
    } idle_ctrl_t;

endpackage

// ===== rtl/hall_tachometer_with_idle_timeout.sv =====
// Top level: hall tachometer with idle timeout, APB register and sequencer.
// Depends on htach_pkg, htach_div and htach_idle.
//
//  port group   direction  transfer when
//  in_*         input      in_valid && in_ready
//  out_*        output     out_valid && out_ready
//  APB          input      psel && penable && pwrite (pready tied high)
//
// A hall edge goes through these steps after its transfer: the capture difference at the
// transfer, the scaling multiply, the launch of the divider, 20 divider steps, taking
// the quotient and loading the result. A zero revolution time skips the divider.
// Button presses, loop ticks and unused codes go straight to loading the result.
// Reset clears all held values and loads the countdown with 50000.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready holds the next result in the sequencer until the output frees.
module hall_tachometer_with_idle_timeout (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [htach_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [htach_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [htach_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [htach_pkg::ACTION_W-1:0]      action,
    input  logic [htach_pkg::CAPTURE_W-1:0]     capture_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [htach_pkg::PERIOD_W-1:0]      period_ticks,
    output logic [htach_pkg::TIME_W-1:0]        revolution_time,
    output logic [htach_pkg::DELAY_W-1:0]       display_delay,
    output logic [htach_pkg::SPEED_W-1:0]       speed_value,
    output logic [htach_pkg::TOTAL_W-1:0]       tick_total,
    output logic                                sleep_request
);
    import htach_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_LAUNCH,
        S_DIV,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [CAPTURE_W-1:0] last_cap_reg, last_cap_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [SPEED_W-1:0]   speed_reg, speed_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 sleep_reg, sleep_next;
    logic                 ov_reg, ov_next;
    logic [PERIOD_W-1:0]  o_period_reg, o_period_next;
    logic [TIME_W-1:0]    o_time_reg, o_time_next;
    logic [DELAY_W-1:0]   o_delay_reg, o_delay_next;
    logic [SPEED_W-1:0]   o_speed_reg, o_speed_next;
    logic [TOTAL_W-1:0]   o_total_reg, o_total_next;
    logic                 o_sleep_reg, o_sleep_next;

    logic                 in_xfer;
    logic                 cfg_wr;
    logic [PERIOD_W-1:0]  ticks;
    logic [PROD_W-1:0]    scale_prod;
    idle_ctrl_t           idle_ctrl;
    logic                 idle_sleep;
    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_q;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_IDLE_TIMEOUT);
    assign pready   = 1'b1;
    assign prdata   = {{(APB_DATA_W-TIMEOUT_W){1'b0}}, timeout_reg};

    assign ticks      = capture_count - last_cap_reg;
    assign scale_prod = PROD_W'(period_reg[PERIOD_W-1:2]) * PROD_W'(THIRD_RECIP);

    always_comb
    begin
        idle_ctrl.reload = in_xfer && (action == ACT_HALL || action == ACT_BUTTON);
        idle_ctrl.tick   = in_xfer && (action == ACT_TICK);
    end

    htach_idle u_idle (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (idle_ctrl),
        .timeout_len (timeout_reg),
        .sleep       (idle_sleep)
    );

    htach_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (SPEED_NUMERATOR),
        .divisor  (time_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        timeout_next  = timeout_reg;
        last_cap_next = last_cap_reg;
        period_next   = period_reg;
        time_next     = time_reg;
        speed_next    = speed_reg;
        total_next    = total_reg;
        sleep_next    = sleep_reg;
        ov_next       = ov_reg;
        o_period_next = o_period_reg;
        o_time_next   = o_time_reg;
        o_delay_next  = o_delay_reg;
        o_speed_next  = o_speed_reg;
        o_total_next  = o_total_reg;
        o_sleep_next  = o_sleep_reg;
        div_start     = 1'b0;

        if (cfg_wr)
        begin
            timeout_next = pwdata[TIMEOUT_W-1:0];
        end

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sleep_next = idle_sleep;
                    if (action == ACT_HALL)
                    begin
                        period_next   = ticks;
                        last_cap_next = capture_count;
                        total_next    = total_reg + TOTAL_W'(ticks);
                        state_next    = S_SCALE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCALE:
            begin
                time_next  = scale_prod[RECIP_SH +: TIME_W];
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                if (time_reg == '0)
                begin
                    speed_next = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_q > DIV_Q_W'(SPEED_MAX))
                    begin
                        speed_next = SPEED_MAX;
                    end
                    else
                    begin
                        speed_next = div_q[SPEED_W-1:0];
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next       = 1'b1;
                    o_period_next = period_reg;
                    o_time_next   = time_reg;
                    o_delay_next  = time_reg[TIME_W-1:2];
                    o_speed_next  = speed_reg;
                    o_total_next  = total_reg;
                    o_sleep_next  = sleep_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            timeout_reg  <= IDLE_RESET_LENGTH;
            last_cap_reg <= '0;
            period_reg   <= '0;
            time_reg     <= '0;
            speed_reg    <= '0;
            total_reg    <= '0;
            sleep_reg    <= 1'b0;
            ov_reg       <= 1'b0;
            o_period_reg <= '0;
            o_time_reg   <= '0;
            o_delay_reg  <= '0;
            o_speed_reg  <= '0;
            o_total_reg  <= '0;
            o_sleep_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            timeout_reg  <= timeout_next;
            last_cap_reg <= last_cap_next;
            period_reg   <= period_next;
            time_reg     <= time_next;
            speed_reg    <= speed_next;
            total_reg    <= total_next;
            sleep_reg    <= sleep_next;
            ov_reg       <= ov_next;
            o_period_reg <= o_period_next;
            o_time_reg   <= o_time_next;
            o_delay_reg  <= o_delay_next;
            o_speed_reg  <= o_speed_next;
            o_total_reg  <= o_total_next;
            o_sleep_reg  <= o_sleep_next;
        end
    end

    assign out_valid       = ov_reg;
    assign period_ticks    = o_period_reg;
    assign revolution_time = o_time_reg;
    assign display_delay   = o_delay_reg;
    assign speed_value     = o_speed_reg;
    assign tick_total      = o_total_reg;
    assign sleep_request   = o_sleep_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider result outside divide state");

    a_delay_match: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> display_delay == revolution_time[TIME_W-1:2])
        else $error("display delay inconsistent with revolution time");

    a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && revolution_time == '0 |-> speed_value == '0)
        else $error("speed non-zero for zero revolution time");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_busy)
        else $error("divider running while sequencer idle");

endmodule

// ===== rtl/htach_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on htach_pkg.
module htach_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [htach_pkg::DIV_Q_W-1:0]    dividend,
    input  logic [htach_pkg::TIME_W-1:0]     divisor,
    output logic                             busy,
    output logic                             done,
    output logic [htach_pkg::DIV_Q_W-1:0]    quotient
);
    import htach_pkg::*;

    logic [DIV_Q_W-1:0]   q_reg, q_next;
    logic [TIME_W:0]      rem_reg, rem_next;
    logic [TIME_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_W:0]      rem_sh;
    logic [TIME_W:0]      rem_sub;

    always_comb
    begin
        rem_sh    = {rem_reg[TIME_W-1:0], q_reg[DIV_Q_W-1]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DIV_STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sub;
                q_next   = {q_reg[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[DIV_Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            q_reg    <= q_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a run");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < {1'b0, dsr_reg})
        else $error("partial remainder out of range");

endmodule

// ===== rtl/htach_idle.sv =====
// Inactivity countdown: reload on activity, decrement on loop ticks, raise sleep at zero.
// Depends on htach_pkg.
module htach_idle (
    input  logic                              clk,
    input  logic                              rst_n,
    input  htach_pkg::idle_ctrl_t             ctrl,
    input  logic [htach_pkg::TIMEOUT_W-1:0]   timeout_len,
    output logic                              sleep
);
    import htach_pkg::*;

    logic [TIMEOUT_W-1:0] cnt_reg, cnt_next;
    logic [TIMEOUT_W-1:0] dec;

    always_comb
    begin
        sleep    = 1'b0;
        cnt_next = cnt_reg;
        dec      = cnt_reg - 1'b1;
        if (ctrl.reload)
        begin
            cnt_next = timeout_len;
        end
        else if (ctrl.tick)
        begin
            if (cnt_reg == '0)
            begin
                sleep    = 1'b1;
                cnt_next = timeout_len;
            end
            else if (dec > timeout_len)
            begin
                cnt_next = timeout_len;
            end
            else
            begin
                cnt_next = dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= IDLE_RESET_LENGTH;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.reload && ctrl.tick))
        else $error("reload and tick together");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.tick |=> cnt_reg <= $past(timeout_len))
        else $error("countdown above timeout after tick");

    a_sleep_reload: assert property (@(posedge clk) disable iff (!rst_n)
        sleep |=> cnt_reg == $past(timeout_len))
        else $error("countdown not reloaded on sleep");

endmodule
